>>> hw/rtl/swrt_pkg.sv
// Shared types and constants of the sliding window range tracker.
package swrt_pkg;

    localparam int DEPTH  = 1024;  // cells per candidate chain
    localparam int DATA_W = 32;
    localparam int SPAN_W = 10;
    // Entries in a chain are never older than DEPTH samples, so 11 bits of
    // position give the exact age.
    localparam int POS_W  = 11;

    typedef logic signed [DATA_W-1:0] sample_t;
    typedef logic [POS_W-1:0]         pos_t;
    typedef logic [SPAN_W-1:0]        span_t;

    // Contents of one cell.
    typedef struct packed {
        logic    valid;
        sample_t value;
        pos_t    pos;
    } cell_data_t;

    // Broadcast to every cell of a chain.
    typedef struct packed {
        logic    shift;    // move every entry one cell towards the front
        logic    push;     // drop dominated entries, append the sample
        logic    clear;    // end of sequence: empty the chain
        logic    want_min;
        sample_t sample;
        pos_t    pos;
    } cell_ctrl_t;

    // From the top level to each chain.
    typedef struct packed {
        logic    active;   // a sample is being worked on
        logic    finish;   // this cycle completes the sample
        logic    last;
        sample_t sample;
        pos_t    pos;
        span_t   span;
    } queue_ctrl_t;

    // From each chain to the top level.
    typedef struct packed {
        logic    need_more;  // the front two entries are both expired
        sample_t front;      // window extreme once the sample is appended
    } queue_stat_t;

endpackage

>>> hw/rtl/swrt_cell.sv
// One cell of a candidate chain: holds a single entry and its position.
module swrt_cell (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  swrt_pkg::cell_ctrl_t    ctrl,
    input  swrt_pkg::cell_data_t    nbr,        // entry of the next cell back
    input  logic                    prev_kept,  // cell in front keeps its entry
    output swrt_pkg::cell_data_t    own,
    output logic                    kept,
    output swrt_pkg::sample_t       src_value
);

    logic              valid_reg, valid_next;
    swrt_pkg::sample_t value_reg, value_next;
    swrt_pkg::pos_t    pos_reg, pos_next;

    swrt_pkg::cell_data_t src;
    logic                 dominated;

    always_comb begin
        src = ctrl.shift ? nbr : own;
        dominated = ctrl.want_min ? (ctrl.sample < src.value) : (ctrl.sample > src.value);
        kept = src.valid && !dominated;
        src_value = src.value;
    end

    always_comb begin
        valid_next = valid_reg;
        value_next = value_reg;
        pos_next   = pos_reg;
        if (ctrl.clear) begin
            valid_next = 1'b0;
        end else if (ctrl.push) begin
            // keep the survivor, or take the sample in the first free cell
            if (kept) begin
                valid_next = 1'b1;
                value_next = src.value;
                pos_next   = src.pos;
            end else if (prev_kept) begin
                valid_next = 1'b1;
                value_next = ctrl.sample;
                pos_next   = ctrl.pos;
            end else begin
                valid_next = 1'b0;
            end
        end else if (ctrl.shift) begin
            valid_next = src.valid;
            value_next = src.value;
            pos_next   = src.pos;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
        pos_reg   <= pos_next;
    end

    assign own = '{valid: valid_reg, value: value_reg, pos: pos_reg};

endmodule

>>> hw/rtl/swrt_queue.sv
// Monotonic candidate chain for either the window minimum or maximum.
module swrt_queue (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   want_min,
    input  swrt_pkg::queue_ctrl_t  ctrl,
    output swrt_pkg::queue_stat_t  stat
);

    swrt_pkg::cell_data_t own   [swrt_pkg::DEPTH];
    swrt_pkg::cell_data_t nbr   [swrt_pkg::DEPTH];
    logic                 kept  [swrt_pkg::DEPTH];
    logic                 prevk [swrt_pkg::DEPTH];
    swrt_pkg::sample_t    srcv  [swrt_pkg::DEPTH];

    swrt_pkg::cell_ctrl_t cctrl;
    swrt_pkg::pos_t       age0, age1;
    logic                 exp0, exp1, need_more;

    // Expiry is only ever tested at the front two cells.
    always_comb begin
        age0 = ctrl.pos - own[0].pos;
        age1 = ctrl.pos - own[1].pos;
        exp0 = own[0].valid && (age0 > swrt_pkg::pos_t'(ctrl.span));
        exp1 = own[1].valid && (age1 > swrt_pkg::pos_t'(ctrl.span));
        need_more = exp0 && exp1;
    end

    always_comb begin
        cctrl.shift    = ctrl.active && exp0 && (need_more || ctrl.finish);
        cctrl.push     = ctrl.finish && !ctrl.last;
        cctrl.clear    = ctrl.finish && ctrl.last;
        cctrl.want_min = want_min;
        cctrl.sample   = ctrl.sample;
        cctrl.pos      = ctrl.pos;
    end

    for (genvar i = 0; i < swrt_pkg::DEPTH; i++) begin : g_cell
        if (i == swrt_pkg::DEPTH - 1) begin : g_tail
            assign nbr[i] = '0;
        end else begin : g_body
            assign nbr[i] = own[i+1];
        end
        if (i == 0) begin : g_head
            assign prevk[i] = 1'b1;
        end else begin : g_rest
            assign prevk[i] = kept[i-1];
        end

        swrt_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (cctrl),
            .nbr       (nbr[i]),
            .prev_kept (prevk[i]),
            .own       (own[i]),
            .kept      (kept[i]),
            .src_value (srcv[i])
        );
    end

    always_comb begin
        stat.need_more = need_more;
        stat.front     = kept[0] ? srcv[0] : ctrl.sample;
    end

endmodule

>>> hw/rtl/sliding_window_range_tracker_unit.sv
// Sliding window range tracker: top level with beat registers and control.
// A result beat is registered at the output when its sample beat completes.
// One beat per cycle while window_span holds and m_tready does not stall the output;
// after a span shrink, a sample waits while extra expired entries are shifted out.
// Two chains of 1024 cells (minimum and maximum) hold the candidates.
// Reset (aresetn low, synchronous) empties both chains and sets window_span to 1.
module sliding_window_range_tracker_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [9:0]  cfg_data,     // window_span
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,      // [31:0] sample
    input  logic        s_tlast,      // last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,      // [31:0] window_range, [63:32] best_range
    output logic        m_tlast       // is_final
);

    swrt_pkg::span_t   span_reg;
    logic              in_full_reg, in_full_next;
    swrt_pkg::sample_t in_sample_reg;
    logic              in_last_reg;
    swrt_pkg::pos_t    pos_reg, pos_next;
    logic [31:0]       best_reg, best_next;
    logic              out_valid_reg, out_valid_next;
    logic [31:0]       out_range_reg, out_best_reg;
    logic              out_last_reg;

    swrt_pkg::queue_ctrl_t qctrl;
    swrt_pkg::queue_stat_t min_stat, max_stat;
    logic                  out_free, finish, s_take;
    logic [31:0]           range;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            span_reg <= swrt_pkg::span_t'(1);
        end else if (cfg_valid) begin
            span_reg <= cfg_data;
        end
    end

    always_comb begin
        out_free = !out_valid_reg || m_tready;
        finish   = in_full_reg && out_free && !min_stat.need_more && !max_stat.need_more;
        s_tready = !in_full_reg || finish;
        s_take   = s_tvalid && s_tready;

        qctrl.active = in_full_reg;
        qctrl.finish = finish;
        qctrl.last   = in_last_reg;
        qctrl.sample = in_sample_reg;
        qctrl.pos    = pos_reg;
        qctrl.span   = span_reg;

        range     = max_stat.front - min_stat.front;
        best_next = (range > best_reg) ? range : best_reg;

        in_full_next   = s_take || (in_full_reg && !finish);
        out_valid_next = finish || (out_valid_reg && !m_tready);
        pos_next       = pos_reg;
        if (finish) begin
            pos_next = in_last_reg ? '0 : pos_reg + swrt_pkg::pos_t'(1);
        end
    end

    swrt_queue u_min_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .want_min (1'b1),
        .ctrl     (qctrl),
        .stat     (min_stat)
    );

    swrt_queue u_max_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .want_min (1'b0),
        .ctrl     (qctrl),
        .stat     (max_stat)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_full_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            pos_reg       <= '0;
            best_reg      <= '0;
        end else begin
            in_full_reg   <= in_full_next;
            out_valid_reg <= out_valid_next;
            pos_reg       <= pos_next;
            // drop the running best at the end of a sequence
            if (finish) begin
                best_reg <= in_last_reg ? '0 : best_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_sample_reg <= s_tdata;
            in_last_reg   <= s_tlast;
        end
        if (finish) begin
            out_range_reg <= range;
            out_best_reg  <= best_next;
            out_last_reg  <= in_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_best_reg, out_range_reg};
    assign m_tlast  = out_last_reg;

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the sliding window range tracker unit.
module tb_top;

    localparam int STALL_LIMIT  = 20000;
    localparam int RESULT_DEPTH = 64;

    typedef enum int {PAT_RANDOM, PAT_NARROW, PAT_RISE, PAT_FALL, PAT_EXTREME} pattern_t;

    typedef struct packed {
        logic [31:0] value;
        logic [31:0] pos;
    } cand_t;

    typedef struct packed {
        logic [31:0] window_range;
        logic [31:0] best_range;
        logic        is_final;
    } range_beat_t;

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [9:0]  cfg_data  = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata   = '0;
    logic        s_tlast   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [63:0] m_tdata;
    logic        m_tlast;

    sliding_window_range_tracker_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // [31:0] sample
        .s_tlast   (s_tlast),   // last
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),   // [31:0] window_range, [63:32] best_range
        .m_tlast   (m_tlast)    // is_final
    );

    // Shadow of the block: candidate rings, position, best range, span.
    cand_t             min_cands[swrt_pkg::DEPTH];
    int                min_head  = 0;
    int                min_count = 0;
    cand_t             max_cands[swrt_pkg::DEPTH];
    int                max_head  = 0;
    int                max_count = 0;
    logic [31:0]       next_pos  = '0;
    logic [31:0]       best_seen = '0;
    swrt_pkg::span_t   span_reg  = 10'd1;

    // Expected result beats, in order.
    range_beat_t range_fifo[RESULT_DEPTH];
    int          fifo_wr = 0;
    int          fifo_rd = 0;

    bit calm = 1'b0;
    int errors = 0;
    int samples_sent = 0;
    int results_seen = 0;
    int sequences_done = 0;
    int spans_written = 0;
    int idle_cycles = 0;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic void track_sample(input logic [31:0] v, input logic lst);
        range_beat_t beat;
        // Expire every stale front entry, then drop the dominated back entries.
        while (min_count != 0 && (next_pos - min_cands[min_head].pos) > span_reg) begin
            min_head = (min_head + 1) % swrt_pkg::DEPTH;
            min_count--;
        end
        while (min_count != 0 && $signed(v) <
               $signed(min_cands[(min_head + min_count - 1) % swrt_pkg::DEPTH].value))
            min_count--;
        min_cands[(min_head + min_count) % swrt_pkg::DEPTH] = '{value: v, pos: next_pos};
        min_count++;
        while (max_count != 0 && (next_pos - max_cands[max_head].pos) > span_reg) begin
            max_head = (max_head + 1) % swrt_pkg::DEPTH;
            max_count--;
        end
        while (max_count != 0 && $signed(v) >
               $signed(max_cands[(max_head + max_count - 1) % swrt_pkg::DEPTH].value))
            max_count--;
        max_cands[(max_head + max_count) % swrt_pkg::DEPTH] = '{value: v, pos: next_pos};
        max_count++;

        beat.window_range = max_cands[max_head].value - min_cands[min_head].value;
        if (beat.window_range > best_seen)
            best_seen = beat.window_range;
        beat.best_range = best_seen;
        beat.is_final   = lst;
        range_fifo[fifo_wr % RESULT_DEPTH] = beat;
        fifo_wr++;

        next_pos = next_pos + 1;
        if (lst) begin
            min_head  = 0;
            min_count = 0;
            max_head  = 0;
            max_count = 0;
            next_pos  = '0;
            best_seen = '0;
            sequences_done++;
        end
    endfunction

    task automatic send_sample(input logic [31:0] v, input logic lst);
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        s_tlast  <= lst;
        do @(posedge aclk); while (!s_tready);
        track_sample(v, lst);
        samples_sent++;
    endtask

    // Write the span only once the block has gone idle.
    task automatic write_span(input swrt_pkg::span_t v);
        s_tvalid <= 1'b0;
        while (fifo_wr != fifo_rd) @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        span_reg = v;
        spans_written++;
    endtask

    function automatic logic [31:0] pick_sample(input pattern_t pat, input int k);
        logic [31:0] v;
        case (pat)
            PAT_NARROW:  v = $urandom_range(0, 6) - 3;
            PAT_RISE:    v = k * 64 + $urandom_range(0, 100);
            PAT_FALL:    v = 32'h1000_0000 - k * 64 - $urandom_range(0, 100);
            PAT_EXTREME: begin
                case ($urandom_range(0, 3))
                    0:       v = 32'h8000_0000;
                    1:       v = 32'h7FFF_FFFF;
                    2:       v = 32'hFFFF_FFFF;
                    default: v = 32'h0000_0000;
                endcase
            end
            default:     v = $urandom;
        endcase
        return v;
    endfunction

    function automatic swrt_pkg::span_t pick_span();
        case ($urandom_range(0, 7))
            0:       return 10'd0;
            1:       return 10'd1023;
            2, 3, 4: return swrt_pkg::span_t'($urandom_range(1, 8));
            default: return swrt_pkg::span_t'($urandom_range(9, 100));
        endcase
    endfunction

    // Receiver: hold tready low for short random bursts.
    initial begin
        forever begin
            @(posedge aclk);
            if (!calm && $urandom_range(0, 6) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        range_beat_t got;
        range_beat_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.window_range = m_tdata[31:0];
            got.best_range   = m_tdata[63:32];
            got.is_final     = m_tlast;
            results_seen++;
            if (fifo_wr == fifo_rd) begin
                errors++;
                $display("%0t: unexpected result beat range %h best %h final %b",
                         $time, got.window_range, got.best_range, got.is_final);
            end else begin
                want = range_fifo[fifo_rd % RESULT_DEPTH];
                fifo_rd++;
                if (got !== want) begin
                    errors++;
                    $display("%0t: expected range %h best %h final %b, got range %h best %h final %b",
                             $time, want.window_range, want.best_range, want.is_final,
                             got.window_range, got.best_range, got.is_final);
                end
            end
        end
    end

    // Watchdog: end the run if no beat moves on any channel for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // First sample, full-scale swing, equal samples, one-sample sequence.
    task automatic test_first_and_extremes();
        send_sample(32'h0000_0000, 1'b0);
        send_sample(32'h7FFF_FFFF, 1'b0);
        send_sample(32'h8000_0000, 1'b0);
        send_sample(32'h8000_0000, 1'b0);
        send_sample(32'hFFFF_FFFF, 1'b0);
        send_sample(32'h0000_0001, 1'b1);
        send_sample(32'h8000_0000, 1'b1);
        send_sample(32'h0000_0005, 1'b0);
        send_sample(32'h0000_0005, 1'b0);
        send_sample(32'h0000_0005, 1'b0);
        send_sample(32'h0000_0004, 1'b0);
        send_sample(32'h0000_0005, 1'b1);
    endtask

    task automatic test_zero_span();
        write_span(10'd0);
        send_sample(32'h8000_0000, 1'b0);
        send_sample(32'h7FFF_FFFF, 1'b0);
        send_sample(32'h5555_5555, 1'b0);
        send_sample(32'hAAAA_AAAA, 1'b1);
    endtask

    // Fill the chains at the widest span, then shrink so many entries expire at once.
    task automatic test_span_shrink();
        write_span(10'd1023);
        for (int k = 0; k < 40; k++)
            send_sample(pick_sample(PAT_RISE, k), 1'b0);
        write_span(10'd2);
        for (int k = 0; k < 8; k++)
            send_sample(pick_sample(PAT_FALL, k), 1'b0);
        write_span(10'd1023);
        for (int k = 0; k < 30; k++)
            send_sample(pick_sample(PAT_FALL, k), 1'b0);
        write_span(10'd0);
        send_sample(pick_sample(PAT_RANDOM, 0), 1'b0);
        send_sample(pick_sample(PAT_RANDOM, 0), 1'b1);
    endtask

    task automatic test_random_sequences(input int target);
        int       len;
        pattern_t pat;
        while (samples_sent < target) begin
            calm = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 2) == 0)
                write_span(pick_span());
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(41, 200) : $urandom_range(1, 40);
            pat = pattern_t'($urandom_range(0, 4));
            for (int k = 0; k < len; k++) begin
                if (k == len / 2 && len > 4 && $urandom_range(0, 7) == 0)
                    write_span(pick_span());
                if ($urandom_range(0, 9) == 0)
                    pat = pattern_t'($urandom_range(0, 4));
                send_sample(pick_sample(pat, k), k == len - 1);
            end
        end
    endtask

    task automatic test_steady_stream(input int count);
        calm = 1'b1;
        write_span(swrt_pkg::span_t'($urandom_range(3, 30)));
        for (int k = 0; k < count; k++)
            send_sample(pick_sample(pattern_t'($urandom_range(0, 4)), k),
                        $urandom_range(0, 24) == 0 || k == count - 1);
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_first_and_extremes();
        test_zero_span();
        test_span_shrink();
        test_random_sequences(900);
        test_steady_stream(150);

        s_tvalid <= 1'b0;
        while (fifo_wr != fifo_rd) @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("Covered %0d samples in %0d sequences over %0d span writes.",
                 samples_sent, sequences_done, spans_written);
        $display("Checked %0d result beats, %0d mismatches.", results_seen, errors);
        if (errors == 0 && fifo_wr == fifo_rd)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/swrt_pkg.sv
hw/rtl/swrt_cell.sv
hw/rtl/swrt_queue.sv
hw/rtl/sliding_window_range_tracker_unit.sv
tb/tb_top.sv
